// File: hw/rtl/regular_polygon_vertex_generator_defines.svh
// Assertion macros used by the polygon generator controller.
`ifndef REGULAR_POLYGON_VERTEX_GENERATOR_DEFINES_SVH
`define REGULAR_POLYGON_VERTEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPVG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rpvg_pkg.sv
package rpvg_pkg;

    localparam int MAX_SIDES_C   = 64;
    localparam int PHASE_BITS_C  = 16;

    localparam int SIDE_W        = 7;
    localparam int SIZE_W        = 16;
    localparam int MODE_W        = 2;
    localparam int VNUM_W        = 6;
    localparam int COORD_W       = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 40;

    localparam int CORDIC_STEPS  = 16;
    localparam int STEP_W        = 4;
    localparam int XY_W          = 34;
    localparam int Z_W           = 33;
    localparam int PROD_W        = 51;

    localparam int DIV_NUM_W     = 48;
    localparam int DIV_DEN_W     = 34;
    localparam int DIV_CNT_W     = 6;

    localparam logic signed [XY_W-1:0] CORDIC_ONE_K = 34'sh26DD3B6A;
    localparam logic [SIDE_W-1:0] MIN_SIDES = 7'd3;
    localparam logic [SIDE_W-1:0] MAX_SIDES_V = SIDE_W'(MAX_SIDES_C);
    localparam logic [SIZE_W-1:0] RADIUS_MAX = 16'hFFFF;
    localparam logic signed [PROD_W-1:0] COORD_LIMIT = 51'sd65535;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_VALUE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP  = 3'd3;

    localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_APOTHEM = 2'd2;

    typedef enum logic [1:0] {
        DIV_ANGLE,
        DIV_RADIUS,
        DIV_INC,
        DIV_START
    } t_div_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_ANG,
        S_COR_ANG,
        S_DIV_RAD,
        S_DIV_INC,
        S_DIV_START,
        S_VSTART,
        S_VCOR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    div_start;
        t_div_op div_op;
        logic    cor_start;
        logic    cor_sel_phase;
        logic    rad_load;
        logic    inc_load;
        logic    phase_load_div;
        logic    phase_clear;
        logic    mul_load;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic cor_done;
        logic cor_busy;
        logic size_div;
        logic half_step;
        logic out_busy;
        logic is_last;
        logic vcnt_zero;
    } t_sts;

    function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] k);
        logic signed [Z_W-1:0] a;
        case (k)
            4'd0:    a = 33'sh20000000;
            4'd1:    a = 33'sh12E4051E;
            4'd2:    a = 33'sh09FB385B;
            4'd3:    a = 33'sh051111D4;
            4'd4:    a = 33'sh028B0D43;
            4'd5:    a = 33'sh0145D7E1;
            4'd6:    a = 33'sh00A2F61E;
            4'd7:    a = 33'sh00517C55;
            4'd8:    a = 33'sh0028BE53;
            4'd9:    a = 33'sh00145F2F;
            4'd10:   a = 33'sh000A2F98;
            4'd11:   a = 33'sh000517CC;
            4'd12:   a = 33'sh00028BE6;
            4'd13:   a = 33'sh000145F3;
            4'd14:   a = 33'sh0000A2F9;
            4'd15:   a = 33'sh0000517C;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/rpvg_div.sv
module rpvg_div
    import rpvg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    logic [DIV_NUM_W-1:0] r_nq;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    // One quotient bit per cycle, numerator shifted out at the top while
    // quotient bits fill in at the bottom of the same register.
    assign trial = {r_rem, r_nq[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_nq;

endmodule

// File: hw/rtl/rpvg_cordic.sv
module rpvg_cordic
    import rpvg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [31:0]            i_turn,
    output logic                   o_busy,
    output logic                   o_done,
    output logic signed [XY_W-1:0] o_cos,
    output logic signed [XY_W-1:0] o_sin
);

    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [STEP_W-1:0]      r_k;
    logic [1:0]             r_quad;
    logic                   r_busy;
    logic                   r_done;
    logic signed [XY_W-1:0] r_cos;
    logic signed [XY_W-1:0] r_sin;

    logic [31:0]            biased;
    logic [1:0]             quad;
    logic [31:0]            rest;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [XY_W-1:0] n_x;
    logic signed [XY_W-1:0] n_y;
    logic signed [Z_W-1:0]  n_z;

    // Nearest quadrant first, so the iterations only cover +-45 degrees.
    assign biased = i_turn + 32'h2000_0000;
    assign quad   = biased[31:30];
    assign rest   = i_turn - {quad, 30'd0};

    assign dx = r_y >>> r_k;
    assign dy = r_x >>> r_k;

    always_comb begin
        if (!r_z[Z_W-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - atan_step(r_k);
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + atan_step(r_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
                if (r_k == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_ONE_K;
            r_y    <= '0;
            r_z    <= Z_W'($signed(rest));
            r_quad <= quad;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            if (r_k == STEP_W'(CORDIC_STEPS - 1)) begin
                case (r_quad)
                    2'd0: begin
                        r_cos <= n_x;
                        r_sin <= n_y;
                    end
                    2'd1: begin
                        r_cos <= -n_y;
                        r_sin <= n_x;
                    end
                    2'd2: begin
                        r_cos <= -n_x;
                        r_sin <= -n_y;
                    end
                    default: begin
                        r_cos <= n_y;
                        r_sin <= -n_x;
                    end
                endcase
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

// File: hw/rtl/rpvg_dp.sv
module rpvg_dp
    import rpvg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_C
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [COORD_W-1:0]    o_vertex_x,
    output logic [COORD_W-1:0]    o_vertex_y,
    output logic [VNUM_W-1:0]     o_vertex_number,
    output logic                  o_last_vertex
);

    localparam logic [DIV_NUM_W-1:0] TURN_ONE  = DIV_NUM_W'(1) << 32;
    localparam logic [DIV_NUM_W-1:0] PHASE_ONE = DIV_NUM_W'(1) << PHASE_BITS;

    logic [SIDE_W-1:0]       r_side_count;
    logic [SIZE_W-1:0]       r_size_value;
    logic [MODE_W-1:0]       r_size_mode;
    logic                    r_half_step;
    logic [SIZE_W-1:0]       r_radius;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [PHASE_BITS-1:0]   r_phase_inc;
    logic [VNUM_W-1:0]       r_vcnt;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic                    r_out_valid;
    logic [COORD_W-1:0]      r_out_x;
    logic [COORD_W-1:0]      r_out_y;
    logic [VNUM_W-1:0]       r_out_num;
    logic                    r_out_last;

    logic [DIV_NUM_W-1:0]    div_num;
    logic [DIV_DEN_W-1:0]    div_den;
    logic                    div_done;
    logic [DIV_NUM_W-1:0]    div_quo;
    logic [31:0]             cor_turn;
    logic                    cor_busy;
    logic                    cor_done;
    logic signed [XY_W-1:0]  cor_cos;
    logic signed [XY_W-1:0]  cor_sin;
    logic                    mode_edge;
    logic                    mode_apo;
    logic signed [XY_W-1:0]  divisor_trig;
    logic [DIV_NUM_W-1:0]    n_ext;
    logic [SIZE_W-1:0]       n_radius;
    logic                    is_last;
    logic [COORD_W-1:0]      coord_x;
    logic [COORD_W-1:0]      coord_y;

    assign mode_edge    = r_size_mode == MODE_EDGE;
    assign mode_apo     = r_size_mode == MODE_APOTHEM;
    assign divisor_trig = mode_edge ? cor_sin : cor_cos;
    assign n_ext        = DIV_NUM_W'(r_side_count);
    assign is_last      = ({1'b0, r_vcnt} + 1'b1) == r_side_count;

    // Operands of the shared divider for each of the four per-request quotients.
    always_comb begin
        case (i_cmd.div_op)
            DIV_ANGLE: begin
                div_num = TURN_ONE + n_ext;
                div_den = DIV_DEN_W'({r_side_count, 1'b0});
            end
            DIV_RADIUS: begin
                div_num = (mode_edge ? (DIV_NUM_W'(r_size_value) << 30)
                                     : (DIV_NUM_W'(r_size_value) << 31))
                          + DIV_NUM_W'($unsigned(divisor_trig));
                div_den = {divisor_trig[XY_W-2:0], 1'b0};
            end
            DIV_INC: begin
                div_num = PHASE_ONE + (n_ext >> 1);
                div_den = DIV_DEN_W'(r_side_count);
            end
            default: begin
                div_num = PHASE_ONE + n_ext;
                div_den = DIV_DEN_W'({r_side_count, 1'b0});
            end
        endcase
    end

    rpvg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign cor_turn = i_cmd.cor_sel_phase ? {r_phase, {(32 - PHASE_BITS){1'b0}}}
                                          : div_quo[31:0];

    rpvg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cor_start),
        .i_turn  (cor_turn),
        .o_busy  (cor_busy),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    always_comb begin
        if (!(mode_edge || mode_apo)) begin
            n_radius = r_size_value;
        end else if (divisor_trig <= 0) begin
            n_radius = RADIUS_MAX;
        end else if (div_quo > DIV_NUM_W'(RADIUS_MAX)) begin
            n_radius = RADIUS_MAX;
        end else begin
            n_radius = div_quo[SIZE_W-1:0];
        end
    end

    function automatic logic [COORD_W-1:0] round_clamp(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        logic signed [PROD_W-1:0] c;
        v = (p + PROD_W'(32'sh2000_0000)) >>> 30;
        if (v > COORD_LIMIT) begin
            c = COORD_LIMIT;
        end else if (v < -COORD_LIMIT) begin
            c = -COORD_LIMIT;
        end else begin
            c = v;
        end
        return c[COORD_W-1:0];
    endfunction

    assign coord_x = round_clamp(r_prod_x);
    assign coord_y = round_clamp(r_prod_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_count <= MIN_SIDES;
            r_size_value <= 16'd256;
            r_size_mode  <= '0;
            r_half_step  <= 1'b0;
            r_radius     <= '0;
            r_phase      <= '0;
            r_phase_inc  <= '0;
            r_vcnt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SIDE_COUNT: begin
                        if (i_cfg_data[SIDE_W-1:0] >= MIN_SIDES) begin
                            r_side_count <= (i_cfg_data[SIDE_W-1:0] > MAX_SIDES_V)
                                            ? MAX_SIDES_V : i_cfg_data[SIDE_W-1:0];
                        end
                    end
                    REG_SIZE_VALUE: r_size_value <= i_cfg_data[SIZE_W-1:0];
                    REG_SIZE_MODE:  r_size_mode  <= i_cfg_data[MODE_W-1:0];
                    REG_HALF_STEP:  r_half_step  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.rad_load) begin
                r_radius <= n_radius;
            end
            if (i_cmd.inc_load) begin
                r_phase_inc <= div_quo[PHASE_BITS-1:0];
            end
            if (i_cmd.phase_clear) begin
                r_phase <= '0;
            end else if (i_cmd.phase_load_div) begin
                r_phase <= div_quo[PHASE_BITS-1:0];
            end else if (i_cmd.out_load) begin
                r_phase <= r_phase + r_phase_inc;
            end
            if (i_cmd.out_load) begin
                r_vcnt <= is_last ? '0 : r_vcnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_prod_x <= $signed({1'b0, r_radius}) * cor_cos;
            r_prod_y <= $signed({1'b0, r_radius}) * cor_sin;
        end
        if (i_cmd.out_load) begin
            r_out_x    <= coord_x;
            r_out_y    <= coord_y;
            r_out_num  <= r_vcnt;
            r_out_last <= is_last;
        end
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.cor_done  = cor_done;
    assign o_sts.cor_busy  = cor_busy;
    assign o_sts.size_div  = mode_edge || mode_apo;
    assign o_sts.half_step = r_half_step;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_sts.is_last   = is_last;
    assign o_sts.vcnt_zero = r_vcnt == '0;

    assign o_out_valid     = r_out_valid;
    assign o_vertex_x      = r_out_x;
    assign o_vertex_y      = r_out_y;
    assign o_vertex_number = r_out_num;
    assign o_last_vertex   = r_out_last;

endmodule

// File: hw/rtl/rpvg_ctrl.sv
`include "regular_polygon_vertex_generator_defines.svh"

module rpvg_ctrl
    import rpvg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_go,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.div_op = DIV_ANGLE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_go) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_ANGLE;
                    n_state         = S_DIV_ANG;
                end
            end
            S_DIV_ANG: begin
                if (i_sts.div_done) begin
                    o_cmd.cor_start = 1'b1;
                    n_state         = S_COR_ANG;
                end
            end
            S_COR_ANG: begin
                if (i_sts.cor_done) begin
                    o_cmd.div_start = 1'b1;
                    if (i_sts.size_div) begin
                        o_cmd.div_op = DIV_RADIUS;
                        n_state      = S_DIV_RAD;
                    end else begin
                        o_cmd.rad_load = 1'b1;
                        o_cmd.div_op   = DIV_INC;
                        n_state        = S_DIV_INC;
                    end
                end
            end
            S_DIV_RAD: begin
                o_cmd.div_op = DIV_RADIUS;
                if (i_sts.div_done) begin
                    o_cmd.rad_load  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_INC;
                    n_state         = S_DIV_INC;
                end
            end
            S_DIV_INC: begin
                if (i_sts.div_done) begin
                    o_cmd.inc_load = 1'b1;
                    if (i_sts.half_step) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_op    = DIV_START;
                        n_state         = S_DIV_START;
                    end else begin
                        o_cmd.phase_clear = 1'b1;
                        n_state           = S_VSTART;
                    end
                end
            end
            S_DIV_START: begin
                if (i_sts.div_done) begin
                    o_cmd.phase_load_div = 1'b1;
                    n_state              = S_VSTART;
                end
            end
            S_VSTART: begin
                o_cmd.cor_start     = 1'b1;
                o_cmd.cor_sel_phase = 1'b1;
                n_state             = S_VCOR;
            end
            S_VCOR: begin
                if (i_sts.cor_done) begin
                    o_cmd.mul_load = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.is_last ? S_IDLE : S_VSTART;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `RPVG_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !i_sts.out_busy, "vertex loaded over a pending transaction")
    `RPVG_ASSERT_NOW(a_idle_count, i_clk, i_rst_n, r_state == S_IDLE, i_sts.vcnt_zero, "vertex counter not cleared after a run")
    `RPVG_ASSERT_NOW(a_cordic_free, i_clk, i_rst_n, o_cmd.cor_start, !i_sts.cor_busy, "CORDIC restarted while busy")
    `RPVG_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_cmd.out_load && i_sts.is_last, r_state == S_IDLE, "run did not end after last vertex")

endmodule

// File: hw/rtl/regular_polygon_vertex_generator.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata[0] go
// m_axis    out  tvalid/tready/tlast    tdata x[16:0], y[33:17], number[39:34]; tlast last
// cfg       in   i_cfg_we               i_cfg_index, i_cfg_data
//
// A request spends its setup in the shared bit-serial divider, up to four quotients per request,
// and in one CORDIC pass. Each vertex then takes a CORDIC pass, one multiply and one load.
// Reset is synchronous and active low; it restores the register defaults.
// A new request is taken only between runs; a stalled output holds the next vertex.
module regular_polygon_vertex_generator
    import rpvg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_C
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] go, [7:1] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [16:0] vertex_x, [33:17] vertex_y,
                                                  // [39:34] vertex_number
    output logic                  m_axis_tlast,   // last_vertex
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd               cmd;
    t_sts               sts;
    logic [COORD_W-1:0] vertex_x;
    logic [COORD_W-1:0] vertex_y;
    logic [VNUM_W-1:0]  vertex_number;

    rpvg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_go    (s_axis_tdata[0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rpvg_dp #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_vertex_x      (vertex_x),
        .o_vertex_y      (vertex_y),
        .o_vertex_number (vertex_number),
        .o_last_vertex   (m_axis_tlast)
    );

    assign m_axis_tdata = {vertex_number, vertex_y, vertex_x};

endmodule
